// File: src/x86se_pkg.sv
// Shared types and constants of the x86 subset executor.
// Holds the opcode list, the request/result payloads and the stack port bundle.
// No dependencies.
`timescale 1ns / 1ps

package x86se_pkg;

	localparam int StackBytes = 1024;
	localparam int RegCount   = 17;
	localparam int RegIdxW    = 5;
	localparam int StackAddrW = $clog2(StackBytes);
	localparam int StackRows  = StackBytes / 4;
	localparam int RowW       = $clog2(StackRows);

	localparam logic [RegIdxW-1:0] SpReg   = RegIdxW'(6);
	localparam logic [RegIdxW-1:0] FlagReg = RegIdxW'(16);
	localparam logic [RegIdxW:0]   RegLimit = (RegIdxW + 1)'(RegCount);

	localparam int CfBit = 0;
	localparam int ZfBit = 6;
	localparam int SfBit = 7;
	localparam int OfBit = 11;

	typedef enum logic [4:0] {
		OP_SUB   = 5'd0,
		OP_ADDRR = 5'd1,
		OP_ADDIR = 5'd2,
		OP_IMUL  = 5'd3,
		OP_MOVRR = 5'd4,
		OP_LOAD  = 5'd5,
		OP_STORE = 5'd6,
		OP_MOVIR = 5'd7,
		OP_PRINT = 5'd8,
		OP_READ  = 5'd9,
		OP_JMP   = 5'd10,
		OP_JBE   = 5'd11,
		OP_JE    = 5'd12,
		OP_JGE   = 5'd13,
		OP_JLE   = 5'd14,
		OP_JL    = 5'd15,
		OP_SHR   = 5'd16,
		OP_CALL  = 5'd17,
		OP_RET   = 5'd18,
		OP_PUSH  = 5'd19,
		OP_POP   = 5'd20,
		OP_CMP   = 5'd21
	} x86se_op_t;

	typedef struct packed {
		logic [4:0]          operation;
		logic [RegIdxW-1:0]  first_reg;
		logic [RegIdxW-1:0]  second_reg;
		logic signed [15:0]  immediate;
		logic signed [31:0]  read_value;
	} x86se_req_t;

	typedef struct packed {
		logic [31:0]         next_pc;
		logic                print_valid;
		logic signed [31:0]  print_value;
		logic                halted;
		logic                fault;
	} x86se_rsp_t;

	typedef struct packed {
		logic                  rd;
		logic                  wr;
		logic [StackAddrW-1:0] addr;
		logic [31:0]           wdata;
	} x86se_mem_req_t;

endpackage

// File: src/x86se_stack.sv
// Byte-addressed little-endian stack memory with unaligned 32-bit word access.
// Four byte lanes, registered read data. Depends on x86se_pkg.
`timescale 1ns / 1ps

module x86se_stack (
	input  logic                     clk,
	input  x86se_pkg::x86se_mem_req_t req,
	output logic [31:0]              rdata
);
	import x86se_pkg::*;

	wire  [3:0][7:0] lane_rd;
	logic [1:0]      off_q;

	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [7:0]            mem_q [StackRows];
		logic [7:0]            rd_q;
		logic [1:0]            ofs;
		logic [StackAddrW-1:0] byte_addr;
		logic [RowW-1:0]       row;

		// ofs is the byte position inside the word that lands in this lane
		assign ofs       = 2'(k) - req.addr[1:0];
		assign byte_addr = req.addr + StackAddrW'(ofs);
		assign row       = byte_addr[StackAddrW-1:2];

		always_ff @(posedge clk) begin
			if (req.wr)
				mem_q[row] <= req.wdata[{ofs, 3'b000} +: 8];
			if (req.rd)
				rd_q <= mem_q[row];
		end

		assign lane_rd[k] = rd_q;
	end

	always_ff @(posedge clk) begin
		if (req.rd)
			off_q <= req.addr[1:0];
	end

	// rotate lanes back into word order
	always_comb begin
		for (int j = 0; j < 4; j++)
			rdata[8*j +: 8] = lane_rd[2'(off_q + 2'(j))];
	end

endmodule

// File: src/x86_subset_instruction_executor.sv
// Top level of the x86 subset executor. Depends on x86se_pkg and x86se_stack.
// Stage 1 registers an accepted request, stage 2 its result. Throughput: one
// request per cycle while rsp_stall holds no result; the registered read of the
// stack memory sets the second stage, and its data is forwarded to the next
// instruction. Reset: registers clear to zero with the stack pointer at the stack
// top, pc clears to zero, the pipeline empties; stack contents are not cleared.
`timescale 1ns / 1ps

module x86_subset_instruction_executor (
	input  logic                  clk,
	input  logic                  arst_n,
	input  x86se_pkg::x86se_req_t req,
	input  logic                  req_valid,
	output logic                  req_stall,
	output x86se_pkg::x86se_rsp_t rsp,
	output logic                  rsp_valid,
	input  logic                  rsp_stall
);
	import x86se_pkg::*;

	logic [31:0] rf_q [RegCount];
	logic [31:0] pc_q;

	// stage 1: request and registered operand reads
	logic        valid_s1;
	x86se_req_t  req_s1;
	logic [31:0] a_raw_s1;
	logic [31:0] b_raw_s1;

	// stage 2: result and pending memory-sourced write
	logic               valid_s2;
	logic [31:0]        next_pc_s2;
	logic               print_valid_s2;
	logic [31:0]        print_value_s2;
	logic               halted_s2;
	logic               fault_s2;
	logic               late_we_s2;
	logic [RegIdxW-1:0] late_idx_s2;
	logic               add4_s2;
	logic               pc_from_mem_s2;

	logic           en;
	logic           accept;
	logic [31:0]    mem_word;
	logic [31:0]    late_val;
	logic           late_fwd;
	x86se_mem_req_t mem_req;

	// execute signals
	logic [31:0]        pc_cur, a, b, sp, fl, imm32, seq, target, addr, diff;
	logic               ra_ok, rb_ok, sf_ne_of;
	logic               ex_we, ex_mem_rd, ex_mem_wr, ex_late_we, ex_add4, ex_pc_from_mem;
	logic [RegIdxW-1:0] ex_widx, ex_late_idx;
	logic [31:0]        ex_wdata, ex_next, ex_mem_addr, ex_mem_wdata;
	logic               ex_pvalid, ex_halt, ex_fault;
	logic [31:0]        ex_pval;
	logic [31:0]        rd_a, rd_b;
	logic               s1_wr;

	assign en        = !valid_s2 || !rsp_stall;
	assign req_stall = !en;
	assign accept    = req_valid && en;

	assign late_fwd = valid_s2 && late_we_s2;
	assign late_val = mem_word + (add4_s2 ? 32'd4 : 32'd0);

	// operands: take the pending load/pop result and return address of the stage ahead
	always_comb begin
		pc_cur = (valid_s2 && pc_from_mem_s2) ? mem_word : pc_q;
		a  = (late_fwd && late_idx_s2 == req_s1.first_reg)  ? late_val : a_raw_s1;
		b  = (late_fwd && late_idx_s2 == req_s1.second_reg) ? late_val : b_raw_s1;
		sp = (late_fwd && late_idx_s2 == SpReg)   ? late_val : rf_q[SpReg];
		fl = (late_fwd && late_idx_s2 == FlagReg) ? late_val : rf_q[FlagReg];
	end

	always_comb begin
		imm32    = {{16{req_s1.immediate[15]}}, req_s1.immediate};
		seq      = pc_cur + 32'd4;
		target   = seq + imm32;
		ra_ok    = {1'b0, req_s1.first_reg} < RegLimit;
		rb_ok    = {1'b0, req_s1.second_reg} < RegLimit;
		sf_ne_of = fl[SfBit] ^ fl[OfBit];
		addr     = '0;
		diff     = b - a;

		ex_we          = 1'b0;
		ex_widx        = req_s1.first_reg;
		ex_wdata       = '0;
		ex_next        = seq;
		ex_pvalid      = 1'b0;
		ex_pval        = '0;
		ex_halt        = 1'b0;
		ex_fault       = 1'b0;
		ex_mem_rd      = 1'b0;
		ex_mem_wr      = 1'b0;
		ex_mem_addr    = '0;
		ex_mem_wdata   = '0;
		ex_late_we     = 1'b0;
		ex_late_idx    = req_s1.first_reg;
		ex_add4        = 1'b0;
		ex_pc_from_mem = 1'b0;

		case (req_s1.operation)
			OP_SUB, OP_ADDIR, OP_MOVIR, OP_READ, OP_SHR: begin
				if (!ra_ok) begin
					ex_fault = 1'b1;
				end else begin
					ex_we = 1'b1;
					case (req_s1.operation)
						OP_SUB:   ex_wdata = a - imm32;
						OP_ADDIR: ex_wdata = a + imm32;
						OP_MOVIR: ex_wdata = imm32;
						OP_READ:  ex_wdata = req_s1.read_value;
						default:  ex_wdata = {1'b0, a[31:1]};
					endcase
				end
			end
			OP_ADDRR, OP_IMUL, OP_MOVRR: begin
				if (!ra_ok || !rb_ok) begin
					ex_fault = 1'b1;
				end else begin
					ex_we   = 1'b1;
					ex_widx = req_s1.second_reg;
					case (req_s1.operation)
						OP_ADDRR: ex_wdata = a + b;
						OP_IMUL:  ex_wdata = a * b;
						default:  ex_wdata = a;
					endcase
				end
			end
			OP_LOAD: begin
				addr = imm32 + a;
				if (!ra_ok || !rb_ok || addr > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_mem_rd   = 1'b1;
					ex_mem_addr = addr;
					ex_late_we  = 1'b1;
					ex_late_idx = req_s1.second_reg;
				end
			end
			OP_STORE: begin
				addr = imm32 + b;
				if (!ra_ok || !rb_ok || addr > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_mem_wr    = 1'b1;
					ex_mem_addr  = addr;
					ex_mem_wdata = a;
				end
			end
			OP_PRINT: begin
				if (!ra_ok) begin
					ex_fault = 1'b1;
				end else begin
					ex_pvalid = 1'b1;
					ex_pval   = a;
				end
			end
			OP_JMP: ex_next = target;
			OP_JBE: if (fl[ZfBit] || fl[CfBit]) ex_next = target;
			OP_JE:  if (fl[ZfBit]) ex_next = target;
			OP_JGE: if (!sf_ne_of) ex_next = target;
			OP_JLE: if (sf_ne_of || fl[ZfBit]) ex_next = target;
			OP_JL:  if (sf_ne_of) ex_next = target;
			OP_CALL: begin
				addr = sp - 32'd4;
				if (addr > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_we        = 1'b1;
					ex_widx      = SpReg;
					ex_wdata     = addr;
					ex_mem_wr    = 1'b1;
					ex_mem_addr  = addr;
					ex_mem_wdata = seq;
					ex_next      = target;
				end
			end
			OP_RET: begin
				if (sp == 32'(StackBytes)) begin
					ex_halt = 1'b1;
					ex_next = pc_cur;
				end else if (sp > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_mem_rd      = 1'b1;
					ex_mem_addr    = sp;
					ex_we          = 1'b1;
					ex_widx        = SpReg;
					ex_wdata       = sp + 32'd4;
					ex_pc_from_mem = 1'b1;
				end
			end
			OP_PUSH: begin
				addr = sp - 32'd4;
				if (!ra_ok || addr > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_we        = 1'b1;
					ex_widx      = SpReg;
					ex_wdata     = addr;
					ex_mem_wr    = 1'b1;
					ex_mem_addr  = addr;
					// pushing the stack pointer stores its decremented value
					ex_mem_wdata = (req_s1.first_reg == SpReg) ? addr : a;
				end
			end
			OP_POP: begin
				if (!ra_ok || sp > 32'(StackBytes - 4)) begin
					ex_fault = 1'b1;
				end else begin
					ex_mem_rd   = 1'b1;
					ex_mem_addr = sp;
					ex_we       = 1'b1;
					ex_widx     = SpReg;
					ex_wdata    = sp + 32'd4;
					ex_late_we  = 1'b1;
					ex_late_idx = req_s1.first_reg;
					// popping into the stack pointer still gets the increment
					ex_add4     = (req_s1.first_reg == SpReg);
				end
			end
			OP_CMP: begin
				if (!ra_ok || !rb_ok) begin
					ex_fault = 1'b1;
				end else begin
					ex_we           = 1'b1;
					ex_widx         = FlagReg;
					ex_wdata[CfBit] = b < a;
					ex_wdata[ZfBit] = (diff == 32'd0);
					ex_wdata[SfBit] = diff[31];
					ex_wdata[OfBit] = ((b[31] ^ a[31]) & (b[31] ^ diff[31]));
				end
			end
			default: ;
		endcase
	end

	assign s1_wr = valid_s1 && ex_we;

	// operand reads for the incoming request, written-through by this edge's updates
	always_comb begin
		rd_a = '0;
		rd_b = '0;
		if ({1'b0, req.first_reg} < RegLimit) begin
			if (s1_wr && ex_widx == req.first_reg)
				rd_a = ex_wdata;
			else if (late_fwd && late_idx_s2 == req.first_reg)
				rd_a = late_val;
			else
				rd_a = rf_q[req.first_reg];
		end
		if ({1'b0, req.second_reg} < RegLimit) begin
			if (s1_wr && ex_widx == req.second_reg)
				rd_b = ex_wdata;
			else if (late_fwd && late_idx_s2 == req.second_reg)
				rd_b = late_val;
			else
				rd_b = rf_q[req.second_reg];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++)
				rf_q[i] <= (i == int'(SpReg)) ? 32'(StackBytes) : 32'd0;
		end else if (en) begin
			// the stage 1 write is younger and wins on the same register
			for (int i = 0; i < RegCount; i++) begin
				if (s1_wr && ex_widx == RegIdxW'(i))
					rf_q[i] <= ex_wdata;
				else if (late_fwd && late_idx_s2 == RegIdxW'(i))
					rf_q[i] <= late_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			if (valid_s1)
				pc_q <= ex_next;
			else if (valid_s2 && pc_from_mem_s2)
				pc_q <= mem_word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req;
			a_raw_s1 <= rd_a;
			b_raw_s1 <= rd_b;
		end
		if (en && valid_s1) begin
			next_pc_s2     <= ex_next;
			print_valid_s2 <= ex_pvalid;
			print_value_s2 <= ex_pval;
			halted_s2      <= ex_halt;
			fault_s2       <= ex_fault;
			late_we_s2     <= ex_late_we;
			late_idx_s2    <= ex_late_idx;
			add4_s2        <= ex_add4;
			pc_from_mem_s2 <= ex_pc_from_mem;
		end
	end

	always_comb begin
		mem_req.rd    = en && valid_s1 && ex_mem_rd;
		mem_req.wr    = en && valid_s1 && ex_mem_wr;
		mem_req.addr  = ex_mem_addr[StackAddrW-1:0];
		mem_req.wdata = ex_mem_wdata;
	end

	x86se_stack u_stack (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_word)
	);

	assign rsp_valid = valid_s2;

	always_comb begin
		rsp.next_pc     = pc_from_mem_s2 ? mem_word : next_pc_s2;
		rsp.print_valid = print_valid_s2;
		rsp.print_value = print_value_s2;
		rsp.halted      = halted_s2;
		rsp.fault       = fault_s2;
	end

endmodule

// File: sim/tb_x86_subset_instruction_executor.sv
// Self-checking testbench for the x86 subset executor: a queued request driver,
// a result monitor and an in-order predictor of registers, stack and pc.
// Depends on x86se_pkg and x86_subset_instruction_executor.
`timescale 1ns / 1ps

module tb_x86_subset_instruction_executor;
	import x86se_pkg::*;

	localparam int RandomItems = 1800;
	localparam int CycleLimit  = 200000;
	localparam int TailCycles  = 12;
	// two copies of the machine: one steers stimulus, one tracks accepted requests
	localparam int PlanCopy = 0;
	localparam int LiveCopy = 1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	x86se_req_t req = '0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	x86se_rsp_t rsp;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;

	logic [31:0] cpu_reg [2][32];
	logic [7:0]  stk_byte [2][StackBytes];
	bit          stk_seen [2][StackBytes];
	logic [31:0] cpu_pc [2];

	x86se_req_t pending_q [$];
	x86se_rsp_t rsp_due_q [$];
	x86se_rsp_t got_q [$];
	int         drain_at [$];

	int n_total, n_issued, n_accepted, n_checked, n_errors, n_cycles;
	int n_prints, n_faults, n_halts;
	int burst_left, gap_left, stall_left, stall_mode;

	x86_subset_instruction_executor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_cpu(input int s);
		int i;
		for (i = 0; i < 32; i++) cpu_reg[s][i] = '0;
		for (i = 0; i < StackBytes; i++) begin
			stk_byte[s][i] = '0;
			stk_seen[s][i] = 1'b0;
		end
		cpu_reg[s][SpReg] = 32'(StackBytes);
		cpu_pc[s] = '0;
	endfunction

	function automatic bit word_ok(input logic [31:0] addr);
		return addr <= 32'(StackBytes - 4);
	endfunction

	function automatic void put_word(input int s, input logic [31:0] addr, input logic [31:0] v);
		int i;
		for (i = 0; i < 4; i++) begin
			stk_byte[s][addr + i] = v[8*i +: 8];
			stk_seen[s][addr + i] = 1'b1;
		end
	endfunction

	// Execute one instruction on copy s. Returns 0, with nothing changed, when
	// it would read stack bytes that were never written.
	function automatic bit step_cpu(input int s, input x86se_req_t q, output x86se_rsp_t o);
		logic [31:0] imm, pc, seq_pc, tgt, nxt, a, b, sp, fl, addr, d, f, word;
		bit ra_ok, rb_ok, rd_ok, cf, zf, sf, of;
		int i;
		o = '0;
		imm = {{16{q.immediate[15]}}, q.immediate};
		pc = cpu_pc[s];
		seq_pc = pc + 32'd4;
		tgt = seq_pc + imm;
		nxt = seq_pc;
		ra_ok = q.first_reg < RegCount;
		rb_ok = q.second_reg < RegCount;
		a = ra_ok ? cpu_reg[s][q.first_reg] : '0;
		b = rb_ok ? cpu_reg[s][q.second_reg] : '0;
		sp = cpu_reg[s][SpReg];
		fl = cpu_reg[s][FlagReg];
		cf = fl[CfBit];
		zf = fl[ZfBit];
		sf = fl[SfBit];
		of = fl[OfBit];
		rd_ok = 1'b0;
		addr = '0;
		case (q.operation)
			OP_LOAD: begin
				addr = imm + a;
				rd_ok = ra_ok && rb_ok && word_ok(addr);
			end
			OP_POP: begin
				addr = sp;
				rd_ok = ra_ok && word_ok(sp);
			end
			OP_RET: begin
				addr = sp;
				rd_ok = sp != 32'(StackBytes) && word_ok(sp);
			end
			default: ;
		endcase
		word = '0;
		if (rd_ok) begin
			for (i = 0; i < 4; i++) begin
				if (!stk_seen[s][addr + i]) return 1'b0;
				word[8*i +: 8] = stk_byte[s][addr + i];
			end
		end
		case (q.operation)
			OP_SUB: begin
				if (!ra_ok) o.fault = 1'b1;
				else cpu_reg[s][q.first_reg] = a - imm;
			end
			OP_ADDRR: begin
				if (!ra_ok || !rb_ok) o.fault = 1'b1;
				else cpu_reg[s][q.second_reg] = a + b;
			end
			OP_ADDIR: begin
				if (!ra_ok) o.fault = 1'b1;
				else cpu_reg[s][q.first_reg] = a + imm;
			end
			OP_IMUL: begin
				if (!ra_ok || !rb_ok) o.fault = 1'b1;
				else cpu_reg[s][q.second_reg] = a * b;
			end
			OP_MOVRR: begin
				if (!ra_ok || !rb_ok) o.fault = 1'b1;
				else cpu_reg[s][q.second_reg] = a;
			end
			OP_LOAD: begin
				if (!rd_ok) o.fault = 1'b1;
				else cpu_reg[s][q.second_reg] = word;
			end
			OP_STORE: begin
				addr = imm + b;
				if (!ra_ok || !rb_ok || !word_ok(addr)) o.fault = 1'b1;
				else put_word(s, addr, a);
			end
			OP_MOVIR: begin
				if (!ra_ok) o.fault = 1'b1;
				else cpu_reg[s][q.first_reg] = imm;
			end
			OP_PRINT: begin
				if (!ra_ok) o.fault = 1'b1;
				else begin
					o.print_valid = 1'b1;
					o.print_value = a;
				end
			end
			OP_READ: begin
				if (!ra_ok) o.fault = 1'b1;
				else cpu_reg[s][q.first_reg] = q.read_value;
			end
			OP_JMP: nxt = tgt;
			OP_JBE: if (zf | cf) nxt = tgt;
			OP_JE:  if (zf) nxt = tgt;
			OP_JGE: if (sf == of) nxt = tgt;
			OP_JLE: if (zf | (sf != of)) nxt = tgt;
			OP_JL:  if (sf != of) nxt = tgt;
			OP_SHR: begin
				if (!ra_ok) o.fault = 1'b1;
				else cpu_reg[s][q.first_reg] = a >> 1;
			end
			OP_CALL: begin
				addr = sp - 32'd4;
				if (!word_ok(addr)) o.fault = 1'b1;
				else begin
					cpu_reg[s][SpReg] = addr;
					put_word(s, addr, seq_pc);
					nxt = tgt;
				end
			end
			OP_RET: begin
				if (sp == 32'(StackBytes)) begin
					o.halted = 1'b1;
					nxt = pc;
				end else if (!rd_ok) o.fault = 1'b1;
				else begin
					nxt = word;
					cpu_reg[s][SpReg] = sp + 32'd4;
				end
			end
			OP_PUSH: begin
				addr = sp - 32'd4;
				if (!ra_ok || !word_ok(addr)) o.fault = 1'b1;
				else begin
					// a push of the stack pointer stores its decremented value
					cpu_reg[s][SpReg] = addr;
					put_word(s, addr, cpu_reg[s][q.first_reg]);
				end
			end
			OP_POP: begin
				if (!rd_ok) o.fault = 1'b1;
				else begin
					cpu_reg[s][q.first_reg] = word;
					cpu_reg[s][SpReg] = cpu_reg[s][SpReg] + 32'd4;
				end
			end
			OP_CMP: begin
				if (!ra_ok || !rb_ok) o.fault = 1'b1;
				else begin
					d = b - a;
					f = '0;
					f[CfBit] = b < a;
					f[ZfBit] = d == 32'd0;
					f[SfBit] = d[31];
					f[OfBit] = (b[31] ^ a[31]) & (b[31] ^ d[31]);
					cpu_reg[s][FlagReg] = f;
				end
			end
			default: ;
		endcase
		cpu_pc[s] = nxt;
		o.next_pc = nxt;
		return 1'b1;
	endfunction

	function automatic void queue_insn(input logic [4:0] op, input logic [4:0] ra,
		input logic [4:0] rb, input logic [15:0] imm, input logic [31:0] rv);
		x86se_req_t q;
		x86se_rsp_t o;
		q.operation = op;
		q.first_reg = ra;
		q.second_reg = rb;
		q.immediate = imm;
		q.read_value = rv;
		// turn a read of never-written stack bytes into an immediate move
		if (!step_cpu(PlanCopy, q, o)) begin
			q.operation = OP_MOVIR;
			void'(step_cpu(PlanCopy, q, o));
		end
		pending_q.push_back(q);
	endfunction

	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 15) == 0) return 5'($urandom_range(RegCount, 31));
		return 5'($urandom_range(0, RegCount - 1));
	endfunction

	// any general register but the stack pointer
	function automatic logic [4:0] pick_scratch();
		logic [4:0] r;
		r = 5'($urandom_range(0, 14));
		if (r >= SpReg) r = r + 5'd1;
		return r;
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 2))
			0: return 16'($urandom());
			1: return 16'($urandom_range(0, 32)) - 16'd16;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'($urandom_range(0, 8));
			default: return $urandom();
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		x86se_rsp_t want;
		bit hold;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				void'(step_cpu(LiveCopy, req, want));
				rsp_due_q.push_back(want);
				n_accepted++;
				n_prints += want.print_valid;
				n_faults += want.fault;
				n_halts += want.halted;
			end
			if (!req_valid || !req_stall) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				hold = drain_at.size() > 0 && drain_at[0] == n_issued &&
					n_checked != n_accepted;
				if (burst_left > 0 && pending_q.size() > 0 && !hold) begin
					if (drain_at.size() > 0 && drain_at[0] == n_issued) void'(drain_at.pop_front());
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
					burst_left--;
					n_issued++;
				end else begin
					req_valid <= 1'b0;
					if (burst_left == 0 && gap_left > 0) gap_left--;
				end
			end
		end
	end

	// result monitor: collect accepted results, stall in phases of varying density
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) got_q.push_back(rsp);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(8, 64);
			end
			stall_left--;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= $urandom_range(0, 3) == 0;
				2: rsp_stall <= $urandom_range(0, 1) == 0;
				default: rsp_stall <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	// compare away from the rising edge so the two queues are settled
	always @(negedge clk) begin
		x86se_rsp_t want, got;
		while (got_q.size() > 0) begin
			got = got_q.pop_front();
			if (rsp_due_q.size() == 0) begin
				n_errors++;
				$display("%0t: result with none outstanding, got %h", $time, got);
			end else begin
				want = rsp_due_q.pop_front();
				n_checked++;
				if (got.next_pc !== want.next_pc) begin
					n_errors++;
					$display("%0t: next_pc expected %h got %h", $time, want.next_pc, got.next_pc);
				end
				if (got.print_valid !== want.print_valid) begin
					n_errors++;
					$display("%0t: print_valid expected %b got %b", $time,
						want.print_valid, got.print_valid);
				end
				if (got.print_value !== want.print_value) begin
					n_errors++;
					$display("%0t: print_value expected %h got %h", $time,
						want.print_value, got.print_value);
				end
				if (got.halted !== want.halted) begin
					n_errors++;
					$display("%0t: halted expected %b got %b", $time, want.halted, got.halted);
				end
				if (got.fault !== want.fault) begin
					n_errors++;
					$display("%0t: fault expected %b got %b", $time, want.fault, got.fault);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d of %0d requests checked",
				n_cycles, n_checked, n_total);
			$display("tb_x86_subset_instruction_executor: errors");
			$finish;
		end
	end

	initial begin
		int n_directed, depth, k, base, where;
		logic [4:0] base_r;
		reset_cpu(PlanCopy);
		reset_cpu(LiveCopy);

		// directed: empty-stack halt, field extremes, every operation, faults
		queue_insn(OP_RET, 5'd0, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_MOVIR, 5'd0, 5'd0, 16'h8000, $urandom());
		queue_insn(OP_MOVIR, 5'd1, 5'd31, 16'h7fff, $urandom());
		queue_insn(OP_READ, 5'd2, 5'd0, 16'h0000, 32'h8000_0000);
		queue_insn(OP_READ, 5'd3, 5'd0, 16'hffff, 32'h7fff_ffff);
		queue_insn(OP_ADDRR, 5'd3, 5'd2, 16'h0000, $urandom());
		queue_insn(OP_SUB, 5'd3, 5'd0, 16'hffff, $urandom());
		queue_insn(OP_ADDIR, 5'd0, 5'd0, 16'h7fff, $urandom());
		queue_insn(OP_IMUL, 5'd3, 5'd1, 16'h0000, $urandom());
		queue_insn(OP_MOVRR, 5'd0, 5'd4, 16'h0000, $urandom());
		queue_insn(OP_SHR, 5'd2, 5'd0, 16'h0000, $urandom());
		// zero minus the most negative value overflows
		queue_insn(OP_CMP, 5'd3, 5'd5, 16'h0000, $urandom());
		queue_insn(OP_JL, 5'd0, 5'd0, 16'h0008, $urandom());
		queue_insn(OP_JLE, 5'd0, 5'd0, 16'h8000, $urandom());
		queue_insn(OP_CMP, 5'd5, 5'd5, 16'h0000, $urandom());
		queue_insn(OP_JE, 5'd0, 5'd0, 16'hfffc, $urandom());
		queue_insn(OP_JBE, 5'd0, 5'd0, 16'h0010, $urandom());
		queue_insn(OP_JGE, 5'd0, 5'd0, 16'h0004, $urandom());
		queue_insn(OP_JMP, 5'd0, 5'd0, 16'h7fff, $urandom());
		queue_insn(OP_PUSH, 5'd2, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_PUSH, SpReg, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_CALL, 5'd0, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_RET, 5'd0, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_POP, SpReg, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_POP, 5'd7, 5'd0, 16'h0000, $urandom());
		queue_insn(OP_STORE, 5'd1, 5'd5, 16'd1020, $urandom());
		queue_insn(OP_LOAD, 5'd5, 5'd8, 16'd1020, $urandom());
		queue_insn(OP_STORE, 5'd1, 5'd5, 16'd1021, $urandom());
		queue_insn(OP_LOAD, 5'd31, 5'd8, 16'h0000, $urandom());
		queue_insn(OP_PRINT, 5'd2, 5'd0, 16'h0000, $urandom());
		queue_insn(5'd31, 5'd17, 5'd17, 16'hffff, $urandom());
		n_directed = pending_q.size();
		drain_at.push_back(n_directed);

		while (pending_q.size() < n_directed + RandomItems) begin
			if (drain_at.size() < 4 && pending_q.size() >= n_directed + 500 * drain_at.size())
				drain_at.push_back(pending_q.size());
			case ($urandom_range(0, 9))
				0, 1: begin
					queue_insn(5'($urandom_range(0, 31)), pick_reg(), pick_reg(), pick_imm(),
						$urandom());
				end
				2: begin
					queue_insn(OP_CMP, pick_reg(), pick_reg(), pick_imm(), $urandom());
					queue_insn(5'($urandom_range(OP_JMP, OP_JL)), pick_reg(), pick_reg(),
						pick_imm(), $urandom());
				end
				3, 4: begin
					// store a word, then load it back through the same base
					base_r = pick_scratch();
					base = $urandom_range(0, StackBytes - 1);
					where = ($urandom_range(0, 7) == 0) ? $urandom_range(StackBytes - 3, 1100)
						: $urandom_range(0, StackBytes - 4);
					queue_insn(OP_MOVIR, base_r, pick_reg(), 16'(base), $urandom());
					queue_insn(OP_STORE, pick_reg(), base_r, 16'(where - base), $urandom());
					if ($urandom_range(0, 1) == 0)
						queue_insn(OP_ADDIR, pick_reg(), pick_reg(), pick_imm(), $urandom());
					queue_insn(OP_LOAD, base_r, pick_reg(), 16'(where - base), $urandom());
				end
				5, 6: begin
					if (cpu_reg[PlanCopy][SpReg] > 32'(StackBytes) ||
						cpu_reg[PlanCopy][SpReg] < 32'd64)
						queue_insn(OP_MOVIR, SpReg, 5'd0, 16'(StackBytes - 4 * $urandom_range(0, 8)),
							$urandom());
					depth = $urandom_range(1, 4);
					for (k = 0; k < depth; k++)
						queue_insn(OP_PUSH, pick_reg(), pick_reg(), pick_imm(), $urandom());
					if ($urandom_range(0, 1) == 0)
						queue_insn(OP_PRINT, pick_reg(), pick_reg(), pick_imm(), $urandom());
					for (k = 0; k < depth; k++)
						queue_insn(OP_POP, pick_reg(), pick_reg(), pick_imm(), $urandom());
				end
				7: begin
					queue_insn(OP_CALL, pick_reg(), pick_reg(), pick_imm(), $urandom());
					repeat ($urandom_range(0, 2))
						queue_insn(OP_ADDIR, pick_scratch(), pick_reg(), pick_imm(), $urandom());
					queue_insn(OP_RET, pick_reg(), pick_reg(), pick_imm(), $urandom());
				end
				8: begin
					queue_insn(OP_READ, pick_reg(), pick_reg(), pick_imm(), pick_word());
					queue_insn(OP_PRINT, pick_reg(), pick_reg(), pick_imm(), $urandom());
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						// empty the stack and return: halt
						queue_insn(OP_MOVIR, SpReg, 5'd0, 16'(StackBytes), $urandom());
						queue_insn(OP_RET, pick_reg(), pick_reg(), pick_imm(), $urandom());
					end else begin
						case ($urandom_range(0, 6))
							0: queue_insn(OP_SUB, pick_reg(), pick_reg(), pick_imm(), $urandom());
							1: queue_insn(OP_ADDRR, pick_reg(), pick_reg(), pick_imm(), $urandom());
							2: queue_insn(OP_ADDIR, pick_reg(), pick_reg(), pick_imm(), $urandom());
							3: queue_insn(OP_IMUL, pick_reg(), pick_reg(), pick_imm(), $urandom());
							4: queue_insn(OP_MOVRR, pick_reg(), pick_reg(), pick_imm(), $urandom());
							5: queue_insn(OP_SHR, pick_reg(), pick_reg(), pick_imm(), $urandom());
							default: queue_insn(OP_MOVIR, pick_reg(), pick_reg(), pick_imm(),
								$urandom());
						endcase
					end
				end
			endcase
		end
		n_total = pending_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (n_accepted == n_total && n_checked == n_total);
		repeat (TailCycles) @(posedge clk);

		$display("executed %0d instructions (%0d directed): %0d prints, %0d faults, %0d halts",
			n_total, n_directed, n_prints, n_faults, n_halts);
		$display("%0d field mismatches over %0d cycles", n_errors, n_cycles);
		if (n_errors == 0 && rsp_due_q.size() == 0) begin
			$display("tb_x86_subset_instruction_executor: clean");
		end else begin
			$display("tb_x86_subset_instruction_executor: errors");
		end
		$finish;
	end

endmodule
